// ===== rtl/dqts_pkg.sv =====
// Shared types and constants for the dual quadrature time setter.
// Used by the channel interfaces, the encoder lanes, the merge stage and the top level.
package dqts_pkg;

    localparam int CFG_DATA_W = 8;

    // Register indexes of the configuration port
    localparam logic CFG_DETENT  = 1'b0;
    localparam logic CFG_VOLSTEP = 1'b1;

    localparam logic [2:0]  DETENT_RESET   = 3'd4;
    localparam logic [7:0]  VOL_STEP_RESET = 8'd50;

    localparam logic [11:0] VOL_RESET = 12'd2047;
    localparam logic [11:0] VOL_MAX   = 12'd4095;
    localparam logic [11:0] VOL_LOW   = 12'd51;
    localparam logic [11:0] VOL_FLOOR = 12'd52;

    localparam logic [5:0]  MIN_WRAP  = 6'd60;
    localparam logic [5:0]  MIN_LAST  = 6'd59;
    localparam logic [4:0]  HOUR_WRAP = 5'd24;
    localparam logic [4:0]  HOUR_LAST = 5'd23;

    // Target codes; the unused code behaves as volume
    localparam logic [1:0] TGT_CLOCK  = 2'd0;
    localparam logic [1:0] TGT_ALARM  = 2'd1;
    localparam logic [1:0] TGT_VOLUME = 2'd2;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_CW   = 2'd1,
        DIR_CCW  = 2'd2
    } t_dir;

    // Indexed by {previous phase, current phase}
    localparam t_dir STEP_DIR [16] = '{
        DIR_NONE, DIR_CW,   DIR_CCW,  DIR_NONE,
        DIR_CCW,  DIR_NONE, DIR_NONE, DIR_CW,
        DIR_CW,   DIR_NONE, DIR_NONE, DIR_CCW,
        DIR_NONE, DIR_CCW,  DIR_CW,   DIR_NONE
    };

    typedef struct packed {
        logic up;
        logic dn;
    } t_count;

    typedef struct packed {
        logic [1:0] left_phase;
        logic [1:0] right_phase;
        logic [1:0] target;
        logic [5:0] cur_minutes;
        logic [4:0] cur_hours;
    } t_sample;

    typedef struct packed {
        logic [5:0]  new_minutes;
        logic [4:0]  new_hours;
        logic        write_time;
        logic [11:0] volume_level;
    } t_result;

endpackage

// ===== rtl/dqts_sample_if.sv =====
// Input channel: one encoder sample beat with valid/ready handshake.
// Depends on dqts_pkg for the payload type.
interface dqts_sample_if;
    logic              valid;
    logic              ready;
    dqts_pkg::t_sample payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/dqts_result_if.sv =====
// Output channel: one result beat with valid/ready handshake.
// Depends on dqts_pkg for the payload type.
interface dqts_result_if;
    logic              valid;
    logic              ready;
    dqts_pkg::t_result payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/dqts_lane.sv =====
// One encoder lane: previous phase, signed detent accumulator and count decision.
// Depends on dqts_pkg for the transition table and the count type.
module dqts_lane (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  logic [1:0]       i_phase,
    input  logic [2:0]       i_thr,
    output dqts_pkg::t_count o_count
);

    logic [1:0]        r_prev;
    logic signed [3:0] r_ticks;
    logic signed [3:0] n_ticks;
    dqts_pkg::t_dir    dir;
    logic signed [4:0] sum;
    logic signed [4:0] thr;

    always_comb begin
        dir = dqts_pkg::STEP_DIR[{r_prev, i_phase}];
        thr = $signed({2'b00, i_thr});
        unique case (dir)
            dqts_pkg::DIR_CW:  sum = {r_ticks[3], r_ticks} + 5'sd1;
            dqts_pkg::DIR_CCW: sum = {r_ticks[3], r_ticks} - 5'sd1;
            default:           sum = {r_ticks[3], r_ticks};
        endcase
        o_count = '0;
        n_ticks = sum[3:0];
        // Clear the accumulator whenever it reaches a detent either way
        if (sum >= thr) begin
            o_count.up = 1'b1;
            n_ticks    = '0;
        end else if (sum <= -thr) begin
            o_count.dn = 1'b1;
            n_ticks    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_ticks <= '0;
        end else if (i_advance) begin
            r_prev  <= i_phase;
            r_ticks <= n_ticks;
        end
    end

endmodule

// ===== rtl/dqts_merge.sv =====
// Merge stage: applies the two lane counts to minutes/hours or to the stored volume.
// Depends on dqts_pkg for constants and the result type.
module dqts_merge (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  logic [1:0]        i_target,
    input  logic [5:0]        i_minutes,
    input  logic [4:0]        i_hours,
    input  dqts_pkg::t_count  i_left,
    input  dqts_pkg::t_count  i_right,
    input  logic [7:0]        i_vol_step,
    output dqts_pkg::t_result o_result
);

    logic [11:0]        r_volume;
    logic [11:0]        n_volume;
    logic               time_mode;
    logic signed [7:0]  mins;
    logic signed [6:0]  hrs;
    logic signed [13:0] delta;
    logic signed [13:0] vol_sum;
    logic signed [13:0] step;
    logic [2:0]         cnt_sel;

    always_comb begin
        time_mode = (i_target == dqts_pkg::TGT_CLOCK) || (i_target == dqts_pkg::TGT_ALARM);

        mins = $signed({2'b00, i_minutes});
        if (i_left.up) begin
            mins = mins + 8'sd1;
        end else if (i_left.dn) begin
            mins = mins - 8'sd1;
        end
        hrs = $signed({2'b00, i_hours});
        if (i_right.up) begin
            hrs = hrs + 7'sd1;
        end else if (i_right.dn) begin
            hrs = hrs - 7'sd1;
        end

        // Net count -2..+2 picks a multiple of the step
        step    = $signed({6'd0, i_vol_step});
        cnt_sel = {2'b00, i_left.up} + {2'b00, i_right.up}
                  - {2'b00, i_left.dn} - {2'b00, i_right.dn};
        unique case (cnt_sel)
            3'd1:    delta = step;
            3'd2:    delta = step <<< 1;
            3'd7:    delta = -step;
            3'd6:    delta = -(step <<< 1);
            default: delta = '0;
        endcase
        vol_sum = $signed({2'b00, r_volume}) + delta;

        n_volume = r_volume;
        if (!time_mode) begin
            priority if (vol_sum > $signed({2'b00, dqts_pkg::VOL_MAX})) begin
                n_volume = dqts_pkg::VOL_MAX;
            end else if (vol_sum < $signed({2'b00, dqts_pkg::VOL_LOW})) begin
                n_volume = dqts_pkg::VOL_FLOOR;
            end else begin
                n_volume = vol_sum[11:0];
            end
        end

        o_result = '0;
        o_result.volume_level = n_volume;
        if (time_mode) begin
            o_result.write_time = 1'b1;
            priority if (mins >= $signed({2'b00, dqts_pkg::MIN_WRAP})) begin
                o_result.new_minutes = mins[5:0] - dqts_pkg::MIN_WRAP;
            end else if (mins < 8'sd0) begin
                o_result.new_minutes = dqts_pkg::MIN_LAST;
            end else begin
                o_result.new_minutes = mins[5:0];
            end
            priority if (hrs >= $signed({2'b00, dqts_pkg::HOUR_WRAP})) begin
                o_result.new_hours = '0;
            end else if (hrs < 7'sd0) begin
                o_result.new_hours = dqts_pkg::HOUR_LAST;
            end else begin
                o_result.new_hours = hrs[4:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volume <= dqts_pkg::VOL_RESET;
        end else if (i_advance) begin
            r_volume <= n_volume;
        end
    end

endmodule

// ===== rtl/dual_quadrature_time_setter_unit.sv =====
// Dual quadrature time setter. Takes one sample beat per clock while ready is high: the
// left and right encoder lanes and the merge stage finish a sample in the cycle it is
// accepted; the result is registered in the output register (skid register on a stall).
// This two-entry buffer admits one more beat while a result waits; input ready drops only
// when both are full. Configuration (detent steps, reset 4; volume step, reset 50) takes
// effect on the next beat. The user must write it only while idle; the unit does not check.
module dual_quadrature_time_setter_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    dqts_sample_if.sink                   i_sample,
    dqts_result_if.source                 o_result,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [dqts_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic [2:0]        r_detent;
    logic [7:0]        r_vol_step;
    logic [2:0]        thr;
    logic              accept;
    dqts_pkg::t_count  left_cnt;
    dqts_pkg::t_count  right_cnt;
    dqts_pkg::t_result merged;

    logic              r_out_v;
    dqts_pkg::t_result r_out;
    logic              r_skid_v;
    dqts_pkg::t_result r_skid;

    assign thr      = (r_detent == 3'd0) ? 3'd1 : r_detent;
    assign accept   = i_sample.valid && i_sample.ready;
    assign i_sample.ready  = !r_skid_v;
    assign o_result.valid  = r_out_v;
    assign o_result.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_detent   <= dqts_pkg::DETENT_RESET;
            r_vol_step <= dqts_pkg::VOL_STEP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dqts_pkg::CFG_DETENT:  r_detent   <= i_cfg_data[2:0];
                dqts_pkg::CFG_VOLSTEP: r_vol_step <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    dqts_lane u_left (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (accept),
        .i_phase   (i_sample.payload.left_phase),
        .i_thr     (thr),
        .o_count   (left_cnt)
    );

    dqts_lane u_right (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (accept),
        .i_phase   (i_sample.payload.right_phase),
        .i_thr     (thr),
        .o_count   (right_cnt)
    );

    dqts_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (accept),
        .i_target   (i_sample.payload.target),
        .i_minutes  (i_sample.payload.cur_minutes),
        .i_hours    (i_sample.payload.cur_hours),
        .i_left     (left_cnt),
        .i_right    (right_cnt),
        .i_vol_step (r_vol_step),
        .o_result   (merged)
    );

    // Output register refills from the skid first; park a new beat in the skid on a stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || o_result.ready) begin
            r_out_v  <= r_skid_v || accept;
            r_skid_v <= 1'b0;
        end else if (accept) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || o_result.ready) begin
            r_out <= r_skid_v ? r_skid : merged;
        end else if (accept) begin
            r_skid <= merged;
        end
    end

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid holds a beat while output register is empty");

    a_lane_count_one_way: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(left_cnt.up && left_cnt.dn) && !(right_cnt.up && right_cnt.dn))
        else $error("lane reports both directions");

    a_volume_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_out.volume_level >= dqts_pkg::VOL_LOW))
        else $error("volume below floor");

    a_hours_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_out.new_hours < dqts_pkg::HOUR_WRAP))
        else $error("hours out of range");

    a_volume_mode_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !r_out.write_time) |-> (r_out.new_minutes == '0 && r_out.new_hours == '0))
        else $error("time fields set in volume mode");
`endif

endmodule
